[rtl/rrcc_pkg.sv]
package rrcc_pkg;

    // Width of one bound inside a window register.
    localparam int unsigned WIN_FIELD_BITS = 10;
    localparam int unsigned WIN_REG_BITS   = 6 * WIN_FIELD_BITS;
    localparam int unsigned LEVEL_OUT_BITS = 10;
    localparam int unsigned CUTOFF_BITS    = 10;
    localparam int unsigned CFG_IDX_BITS   = 3;

    // Readings whose difference does not exceed this margin count as zero.
    localparam int unsigned NO_COLOR_MARGIN = 3;
    // All three levels at or below this limit mean no surface color.
    localparam int unsigned NO_COLOR_LIMIT  = 10;

    // Result class codes.
    localparam logic [2:0] CLS_NONE    = 3'd0;
    localparam logic [2:0] CLS_BLACK   = 3'd1;
    localparam logic [2:0] CLS_BLUE    = 3'd2;
    localparam logic [2:0] CLS_GREEN   = 3'd3;
    localparam logic [2:0] CLS_YELLOW  = 3'd4;
    localparam logic [2:0] CLS_RED     = 3'd5;
    localparam logic [2:0] CLS_WHITE   = 3'd6;
    localparam logic [2:0] CLS_UNKNOWN = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLACK_WINDOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLUE_WINDOW   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GREEN_WINDOW  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RED_WINDOW    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WHITE_WINDOW  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_YELLOW_WINDOW = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DARK_CUTOFF   = 3'd6;

    // One window register; red minimum sits at bit 0.
    typedef struct packed {
        logic [WIN_FIELD_BITS-1:0] blue_max;
        logic [WIN_FIELD_BITS-1:0] green_max;
        logic [WIN_FIELD_BITS-1:0] red_max;
        logic [WIN_FIELD_BITS-1:0] blue_min;
        logic [WIN_FIELD_BITS-1:0] green_min;
        logic [WIN_FIELD_BITS-1:0] red_min;
    } window_t;

    // The full set of classification settings.
    typedef struct packed {
        window_t                black;
        window_t                blue;
        window_t                green;
        window_t                red;
        window_t                white;
        window_t                yellow;
        logic [CUTOFF_BITS-1:0] dark_cutoff;
    } class_cfg_t;

endpackage

[rtl/rrcc_classify.sv]
module rrcc_classify
    import rrcc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0]    red_lit,
    input  logic [SAMPLE_BITS-1:0]    red_unlit,
    input  logic [SAMPLE_BITS-1:0]    green_lit,
    input  logic [SAMPLE_BITS-1:0]    green_unlit,
    input  logic [SAMPLE_BITS-1:0]    blue_lit,
    input  logic [SAMPLE_BITS-1:0]    blue_unlit,
    input  class_cfg_t                cfg,
    output logic [2:0]                color_class,
    output logic                      is_dark,
    output logic [LEVEL_OUT_BITS-1:0] red_level,
    output logic [LEVEL_OUT_BITS-1:0] green_level,
    output logic [LEVEL_OUT_BITS-1:0] blue_level
);

    // Comparisons run at the wider of the sample and window field widths.
    localparam int unsigned CMP_W =
        (SAMPLE_BITS > WIN_FIELD_BITS) ? SAMPLE_BITS : WIN_FIELD_BITS;

    logic [CMP_W-1:0] red_lvl;
    logic [CMP_W-1:0] green_lvl;
    logic [CMP_W-1:0] blue_lvl;
    logic             all_low;

    // Lit minus dark, with the margin removed and negatives clamped to zero.
    function automatic logic [CMP_W-1:0] level_of(
        input logic [SAMPLE_BITS-1:0] lit,
        input logic [SAMPLE_BITS-1:0] unlit
    );
        logic [SAMPLE_BITS:0] diff;
        logic [SAMPLE_BITS:0] margin;
        logic [SAMPLE_BITS:0] res;
        diff   = {1'b0, lit} - {1'b0, unlit};
        margin = (SAMPLE_BITS+1)'(NO_COLOR_MARGIN);
        if (diff[SAMPLE_BITS] || (diff <= margin)) begin
            res = '0;
        end else begin
            res = diff - margin;
        end
        return CMP_W'(res[SAMPLE_BITS-1:0]);
    endfunction

    // All three levels lie inside a window, bounds inclusive.
    function automatic logic inside_win(
        input window_t          w,
        input logic [CMP_W-1:0] r,
        input logic [CMP_W-1:0] g,
        input logic [CMP_W-1:0] b
    );
        return (r >= CMP_W'(w.red_min))   && (r <= CMP_W'(w.red_max))   &&
               (g >= CMP_W'(w.green_min)) && (g <= CMP_W'(w.green_max)) &&
               (b >= CMP_W'(w.blue_min))  && (b <= CMP_W'(w.blue_max));
    endfunction

    assign red_lvl   = level_of(red_lit, red_unlit);
    assign green_lvl = level_of(green_lit, green_unlit);
    assign blue_lvl  = level_of(blue_lit, blue_unlit);

    assign all_low = (red_lvl <= CMP_W'(NO_COLOR_LIMIT)) &&
                     (green_lvl <= CMP_W'(NO_COLOR_LIMIT)) &&
                     (blue_lvl <= CMP_W'(NO_COLOR_LIMIT));

    // Fixed priority classification; the first match wins.
    always_comb begin
        priority if (all_low) begin
            color_class = CLS_NONE;
        end else if (inside_win(cfg.black, red_lvl, green_lvl, blue_lvl)) begin
            color_class = CLS_BLACK;
        end else if (inside_win(cfg.blue, red_lvl, green_lvl, blue_lvl) &&
                     (blue_lvl > red_lvl) && (blue_lvl > green_lvl)) begin
            color_class = CLS_BLUE;
        end else if (inside_win(cfg.green, red_lvl, green_lvl, blue_lvl) &&
                     (green_lvl > red_lvl) && (green_lvl > blue_lvl)) begin
            color_class = CLS_GREEN;
        end else if (inside_win(cfg.red, red_lvl, green_lvl, blue_lvl) &&
                     (red_lvl > green_lvl) && (red_lvl > blue_lvl)) begin
            color_class = CLS_RED;
        end else if (inside_win(cfg.white, red_lvl, green_lvl, blue_lvl)) begin
            color_class = CLS_WHITE;
        end else if (inside_win(cfg.yellow, red_lvl, green_lvl, blue_lvl)) begin
            color_class = CLS_YELLOW;
        end else begin
            color_class = CLS_UNKNOWN;
        end
    end

    // The dark flag uses the full red level.
    assign is_dark = (red_lvl <= CMP_W'(cfg.dark_cutoff));

    // Reported levels keep their low bits only.
    assign red_level   = red_lvl[LEVEL_OUT_BITS-1:0];
    assign green_level = green_lvl[LEVEL_OUT_BITS-1:0];
    assign blue_level  = blue_lvl[LEVEL_OUT_BITS-1:0];

endmodule

[rtl/rgb_reflectance_color_classifier_top.sv]
// RGB reflectance color classifier.
//
// The input channel (s_valid/s_ready) carries one word of six photodiode
// readings: red, green and blue, each with its LED lit and dark. The result
// channel (m_valid/m_ready) returns one word per input word: the color
// class, a dark flag and the three corrected levels, in input order.
// Window and cutoff registers are loaded through cfg_wr_en, cfg_index and
// cfg_wdata; a write takes effect at the clock edge and should be done
// while no word is in flight.
//
// From input acceptance to m_valid, a word passes the input register and
// then the result register, which loads the level and classification
// result. Throughput is one word per cycle while m_ready stays high, set
// by the single pass through that logic. A stalled receiver holds the
// result register; the input register keeps filling until it is also
// occupied, after which s_ready drops. Synchronous reset (aresetn low)
// empties both stages and clears all configuration registers to zero.
module rgb_reflectance_color_classifier_top
    import rrcc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SAMPLE_BITS-1:0]    s_red_lit,
    input  logic [SAMPLE_BITS-1:0]    s_red_unlit,
    input  logic [SAMPLE_BITS-1:0]    s_green_lit,
    input  logic [SAMPLE_BITS-1:0]    s_green_unlit,
    input  logic [SAMPLE_BITS-1:0]    s_blue_lit,
    input  logic [SAMPLE_BITS-1:0]    s_blue_unlit,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_color_class,
    output logic                      m_is_dark,
    output logic [LEVEL_OUT_BITS-1:0] m_red_level,
    output logic [LEVEL_OUT_BITS-1:0] m_green_level,
    output logic [LEVEL_OUT_BITS-1:0] m_blue_level,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [WIN_REG_BITS-1:0]   cfg_wdata
);

    class_cfg_t cfg_reg;

    logic                   in_vld_reg;
    logic [SAMPLE_BITS-1:0] red_lit_reg;
    logic [SAMPLE_BITS-1:0] red_unlit_reg;
    logic [SAMPLE_BITS-1:0] green_lit_reg;
    logic [SAMPLE_BITS-1:0] green_unlit_reg;
    logic [SAMPLE_BITS-1:0] blue_lit_reg;
    logic [SAMPLE_BITS-1:0] blue_unlit_reg;
    logic                   in_ready;

    logic                      out_vld_reg;
    logic [2:0]                class_reg;
    logic                      dark_reg;
    logic [LEVEL_OUT_BITS-1:0] red_level_reg;
    logic [LEVEL_OUT_BITS-1:0] green_level_reg;
    logic [LEVEL_OUT_BITS-1:0] blue_level_reg;
    logic                      out_ready;

    logic [2:0]                class_next;
    logic                      dark_next;
    logic [LEVEL_OUT_BITS-1:0] red_level_next;
    logic [LEVEL_OUT_BITS-1:0] green_level_next;
    logic [LEVEL_OUT_BITS-1:0] blue_level_next;

    // Configuration registers; an unused index writes nothing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BLACK_WINDOW:  cfg_reg.black       <= window_t'(cfg_wdata);
                CFG_BLUE_WINDOW:   cfg_reg.blue        <= window_t'(cfg_wdata);
                CFG_GREEN_WINDOW:  cfg_reg.green       <= window_t'(cfg_wdata);
                CFG_RED_WINDOW:    cfg_reg.red         <= window_t'(cfg_wdata);
                CFG_WHITE_WINDOW:  cfg_reg.white       <= window_t'(cfg_wdata);
                CFG_YELLOW_WINDOW: cfg_reg.yellow      <= window_t'(cfg_wdata);
                CFG_DARK_CUTOFF:   cfg_reg.dark_cutoff <= cfg_wdata[CUTOFF_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Each stage may load when it is empty or its word moves on this cycle.
    assign out_ready = !out_vld_reg || m_ready;
    assign in_ready  = !in_vld_reg || out_ready;
    assign s_ready   = in_ready;

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_ready) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (s_valid && in_ready) begin
            red_lit_reg     <= s_red_lit;
            red_unlit_reg   <= s_red_unlit;
            green_lit_reg   <= s_green_lit;
            green_unlit_reg <= s_green_unlit;
            blue_lit_reg    <= s_blue_lit;
            blue_unlit_reg  <= s_blue_unlit;
        end
    end

    rrcc_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .red_lit     (red_lit_reg),
        .red_unlit   (red_unlit_reg),
        .green_lit   (green_lit_reg),
        .green_unlit (green_unlit_reg),
        .blue_lit    (blue_lit_reg),
        .blue_unlit  (blue_unlit_reg),
        .cfg         (cfg_reg),
        .color_class (class_next),
        .is_dark     (dark_next),
        .red_level   (red_level_next),
        .green_level (green_level_next),
        .blue_level  (blue_level_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (in_vld_reg && out_ready) begin
            class_reg       <= class_next;
            dark_reg        <= dark_next;
            red_level_reg   <= red_level_next;
            green_level_reg <= green_level_next;
            blue_level_reg  <= blue_level_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_color_class = class_reg;
    assign m_is_dark     = dark_reg;
    assign m_red_level   = red_level_reg;
    assign m_green_level = green_level_reg;
    assign m_blue_level  = blue_level_reg;

    // A word in the input stage always advances when the result side frees.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_ready |=> out_vld_reg)
        else $error("input stage word did not reach the result register");

    // An accepted word always lands in the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_vld_reg)
        else $error("accepted word lost at the input stage");

    // No color is reported only for three low levels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_color_class == CLS_NONE) |->
            (m_red_level <= LEVEL_OUT_BITS'(NO_COLOR_LIMIT)) &&
            (m_green_level <= LEVEL_OUT_BITS'(NO_COLOR_LIMIT)) &&
            (m_blue_level <= LEVEL_OUT_BITS'(NO_COLOR_LIMIT)))
        else $error("no color class with a high level");

    // Blue needs a strictly dominant blue level, checked when reported levels keep every bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_color_class == CLS_BLUE) |->
            (SAMPLE_BITS > LEVEL_OUT_BITS) ||
            ((m_blue_level > m_red_level) && (m_blue_level > m_green_level)))
        else $error("blue class without dominant blue level");

endmodule

[test/rgb_reflectance_color_classifier_top_test.sv]
module rgb_reflectance_color_classifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rrcc_pkg::*;

    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int unsigned LEVEL_TOP   = SAMPLE_MAX - NO_COLOR_MARGIN;
    localparam int unsigned FIELD_TOP   = (1 << WIN_FIELD_BITS) - 1;
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned RANDOM_SETS = 6;
    localparam int unsigned WORDS_PER_SET = 100;

    // Index past the last register; writes to it must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_INDEX = 3'd7;

    localparam window_t FULL_WINDOW = '{red_min: '0, green_min: '0, blue_min: '0,
                                        red_max: '1, green_max: '1, blue_max: '1};

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_lit;
        logic [SAMPLE_W-1:0] red_unlit;
        logic [SAMPLE_W-1:0] green_lit;
        logic [SAMPLE_W-1:0] green_unlit;
        logic [SAMPLE_W-1:0] blue_lit;
        logic [SAMPLE_W-1:0] blue_unlit;
    } reading_t;

    typedef struct packed {
        logic [2:0]                color_class;
        logic                      is_dark;
        logic [LEVEL_OUT_BITS-1:0] red_level;
        logic [LEVEL_OUT_BITS-1:0] green_level;
        logic [LEVEL_OUT_BITS-1:0] blue_level;
    } color_word_t;

    // Holds a copy of the classifier settings and the colors still owed by the block.
    class color_scoreboard;
        class_cfg_t  settings;
        color_word_t pending_colors[$];
        int unsigned mismatches;
        int unsigned words_checked;
        int unsigned class_seen[8];

        function new();
            settings = '0;
            mismatches = 0;
            words_checked = 0;
            foreach (class_seen[i]) class_seen[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [WIN_REG_BITS-1:0] data);
            case (idx)
                CFG_BLACK_WINDOW:  settings.black = data;
                CFG_BLUE_WINDOW:   settings.blue = data;
                CFG_GREEN_WINDOW:  settings.green = data;
                CFG_RED_WINDOW:    settings.red = data;
                CFG_WHITE_WINDOW:  settings.white = data;
                CFG_YELLOW_WINDOW: settings.yellow = data;
                CFG_DARK_CUTOFF:   settings.dark_cutoff = data[CUTOFF_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Lit minus dark, with anything up to the margin (negative too) read as zero.
        function logic [LEVEL_OUT_BITS-1:0] corrected(logic [SAMPLE_W-1:0] lit,
                                                      logic [SAMPLE_W-1:0] unlit);
            int lit_i;
            int unlit_i;
            int diff;
            lit_i = int'(lit);
            unlit_i = int'(unlit);
            diff = lit_i - unlit_i;
            if (diff <= int'(NO_COLOR_MARGIN)) begin
                return '0;
            end
            return LEVEL_OUT_BITS'(diff - int'(NO_COLOR_MARGIN));
        endfunction

        function bit in_window(window_t w, logic [LEVEL_OUT_BITS-1:0] r,
                               logic [LEVEL_OUT_BITS-1:0] g, logic [LEVEL_OUT_BITS-1:0] b);
            return r >= w.red_min && g >= w.green_min && b >= w.blue_min &&
                   r <= w.red_max && g <= w.green_max && b <= w.blue_max;
        endfunction

        // Fixed-priority classification; the first matching class wins.
        function color_word_t classify(reading_t rd);
            color_word_t c;
            logic [LEVEL_OUT_BITS-1:0] r;
            logic [LEVEL_OUT_BITS-1:0] g;
            logic [LEVEL_OUT_BITS-1:0] b;
            r = corrected(rd.red_lit, rd.red_unlit);
            g = corrected(rd.green_lit, rd.green_unlit);
            b = corrected(rd.blue_lit, rd.blue_unlit);
            if (r <= NO_COLOR_LIMIT && g <= NO_COLOR_LIMIT && b <= NO_COLOR_LIMIT) begin
                c.color_class = CLS_NONE;
            end else if (in_window(settings.black, r, g, b)) begin
                c.color_class = CLS_BLACK;
            end else if (in_window(settings.blue, r, g, b) && b > r && b > g) begin
                c.color_class = CLS_BLUE;
            end else if (in_window(settings.green, r, g, b) && g > r && g > b) begin
                c.color_class = CLS_GREEN;
            end else if (in_window(settings.red, r, g, b) && r > g && r > b) begin
                c.color_class = CLS_RED;
            end else if (in_window(settings.white, r, g, b)) begin
                c.color_class = CLS_WHITE;
            end else if (in_window(settings.yellow, r, g, b)) begin
                c.color_class = CLS_YELLOW;
            end else begin
                c.color_class = CLS_UNKNOWN;
            end
            c.is_dark = (r <= settings.dark_cutoff);
            c.red_level = r;
            c.green_level = g;
            c.blue_level = b;
            return c;
        endfunction

        function void note_reading(reading_t rd);
            pending_colors.push_back(classify(rd));
        endfunction

        function void compare_field(string name, logic [LEVEL_OUT_BITS-1:0] want,
                                    logic [LEVEL_OUT_BITS-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_color(color_word_t got);
            color_word_t want;
            if (pending_colors.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected, got class %0d %s %0d %0d %0d",
                         $time, got.color_class, "levels", got.red_level,
                         got.green_level, got.blue_level);
                return;
            end
            want = pending_colors.pop_front();
            words_checked++;
            if (!$isunknown(got.color_class)) class_seen[got.color_class]++;
            compare_field("color_class", want.color_class, got.color_class);
            compare_field("is_dark", want.is_dark, got.is_dark);
            compare_field("red_level", want.red_level, got.red_level);
            compare_field("green_level", want.green_level, got.green_level);
            compare_field("blue_level", want.blue_level, got.blue_level);
        endfunction

        function int unsigned pending();
            return pending_colors.size();
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [SAMPLE_W-1:0]       s_red_lit = '0;
    logic [SAMPLE_W-1:0]       s_red_unlit = '0;
    logic [SAMPLE_W-1:0]       s_green_lit = '0;
    logic [SAMPLE_W-1:0]       s_green_unlit = '0;
    logic [SAMPLE_W-1:0]       s_blue_lit = '0;
    logic [SAMPLE_W-1:0]       s_blue_unlit = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [2:0]                m_color_class;
    logic                      m_is_dark;
    logic [LEVEL_OUT_BITS-1:0] m_red_level;
    logic [LEVEL_OUT_BITS-1:0] m_green_level;
    logic [LEVEL_OUT_BITS-1:0] m_blue_level;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [WIN_REG_BITS-1:0]   cfg_wdata = '0;

    color_scoreboard sb = new();
    bit              no_idle = 1'b0;
    int unsigned     cycle_count = 0;
    int unsigned     words_sent = 0;
    int unsigned     settings_loaded = 0;

    rgb_reflectance_color_classifier_top #(
        .SAMPLE_BITS(SAMPLE_W)
    ) u_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("[rgb_reflectance_color_classifier_top] ERROR");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    // Result side: random stalls, then take and check each word.
    initial begin
        int unsigned gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_color('{color_class: m_color_class, is_dark: m_is_dark,
                             red_level: m_red_level, green_level: m_green_level,
                             blue_level: m_blue_level});
        end
    end

    task automatic send_reading(reading_t rd);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red_lit <= rd.red_lit;
        s_red_unlit <= rd.red_unlit;
        s_green_lit <= rd.green_lit;
        s_green_unlit <= rd.green_unlit;
        s_blue_lit <= rd.blue_lit;
        s_blue_unlit <= rd.blue_unlit;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_reading(rd);
        words_sent++;
    endtask

    // A lit/dark pair that yields the given level; level zero also gets negative pairs.
    function automatic logic [2*SAMPLE_W-1:0] chan_pair(int unsigned level);
        int unsigned diff;
        int unsigned unlit;
        int unsigned lit;
        if (level == 0) begin
            unlit = $urandom_range(0, SAMPLE_MAX);
            lit = $urandom_range(0, (unlit + NO_COLOR_MARGIN > SAMPLE_MAX) ?
                                    SAMPLE_MAX : unlit + NO_COLOR_MARGIN);
        end else begin
            diff = level + NO_COLOR_MARGIN;
            unlit = $urandom_range(0, SAMPLE_MAX - diff);
            lit = unlit + diff;
        end
        return {lit[SAMPLE_W-1:0], unlit[SAMPLE_W-1:0]};
    endfunction

    task automatic send_levels(int unsigned r, int unsigned g, int unsigned b);
        reading_t rd;
        {rd.red_lit, rd.red_unlit} = chan_pair(r);
        {rd.green_lit, rd.green_unlit} = chan_pair(g);
        {rd.blue_lit, rd.blue_unlit} = chan_pair(b);
        send_reading(rd);
    endtask

    // Stop sending and wait for every owed result word.
    task automatic settle_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_IDX_BITS-1:0] idx, logic [WIN_REG_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // Write all registers, with junk above the cutoff and a write to the spare index.
    task automatic load_settings(class_cfg_t c);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        put_reg(CFG_BLACK_WINDOW, c.black);
        put_reg(CFG_BLUE_WINDOW, c.blue);
        put_reg(CFG_GREEN_WINDOW, c.green);
        put_reg(CFG_RED_WINDOW, c.red);
        put_reg(CFG_WHITE_WINDOW, c.white);
        put_reg(CFG_YELLOW_WINDOW, c.yellow);
        put_reg(CFG_DARK_CUTOFF, {junk[WIN_REG_BITS-1:CUTOFF_BITS], c.dark_cutoff});
        junk = {$urandom, $urandom};
        put_reg(CFG_SPARE_INDEX, junk[WIN_REG_BITS-1:0]);
        cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    function automatic window_t random_window();
        window_t w;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        w = raw[WIN_REG_BITS-1:0];
        case ($urandom_range(0, 7))
            0: w = '1;
            1: w = '0;
            2: w = FULL_WINDOW;
            3: ;
            default: begin
                if (w.red_min > w.red_max) {w.red_min, w.red_max} = {w.red_max, w.red_min};
                if (w.green_min > w.green_max) begin
                    {w.green_min, w.green_max} = {w.green_max, w.green_min};
                end
                if (w.blue_min > w.blue_max) {w.blue_min, w.blue_max} = {w.blue_max, w.blue_min};
            end
        endcase
        return w;
    endfunction

    function automatic class_cfg_t random_settings();
        class_cfg_t c;
        c.black = random_window();
        c.blue = random_window();
        c.green = random_window();
        c.red = random_window();
        c.white = random_window();
        c.yellow = random_window();
        case ($urandom_range(0, 3))
            0: c.dark_cutoff = '0;
            1: c.dark_cutoff = '1;
            default: c.dark_cutoff = CUTOFF_BITS'($urandom_range(0, FIELD_TOP));
        endcase
        return c;
    endfunction

    function automatic int unsigned level_between(int unsigned lo, int unsigned hi);
        if (hi > LEVEL_TOP) hi = LEVEL_TOP;
        if (lo > hi) return $urandom_range(0, LEVEL_TOP);
        return $urandom_range(lo, hi);
    endfunction

    // Mostly levels aimed into one of the loaded windows, plus small, full-range and raw readings.
    task automatic send_random_reading();
        window_t w;
        reading_t rd;
        logic [63:0] raw;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            raw = {$urandom, $urandom};
            rd = raw[6*SAMPLE_W-1:0];
            send_reading(rd);
        end else if (mode == 1) begin
            send_levels($urandom_range(0, 14), $urandom_range(0, 14), $urandom_range(0, 14));
        end else if (mode <= 3) begin
            send_levels($urandom_range(0, LEVEL_TOP), $urandom_range(0, LEVEL_TOP),
                        $urandom_range(0, LEVEL_TOP));
        end else begin
            case ($urandom_range(0, 5))
                0: w = sb.settings.black;
                1: w = sb.settings.blue;
                2: w = sb.settings.green;
                3: w = sb.settings.red;
                4: w = sb.settings.white;
                default: w = sb.settings.yellow;
            endcase
            send_levels(level_between(w.red_min, w.red_max),
                        level_between(w.green_min, w.green_max),
                        level_between(w.blue_min, w.blue_max));
        end
    endtask

    initial begin
        class_cfg_t demo;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: all windows zero, cutoff zero.
        send_reading('{red_lit: '1, red_unlit: '0, green_lit: '1, green_unlit: '0,
                       blue_lit: '1, blue_unlit: '0});
        send_reading('0);
        send_reading('{red_lit: '0, red_unlit: '1, green_lit: '0, green_unlit: '1,
                       blue_lit: '0, blue_unlit: '1});
        settle_results();

        // Hand-picked windows so that every class can be reached.
        demo.black  = '{red_min: 0, green_min: 0, blue_min: 0,
                        red_max: 60, green_max: 60, blue_max: 60};
        demo.blue   = '{red_min: 0, green_min: 0, blue_min: 100,
                        red_max: '1, green_max: '1, blue_max: '1};
        demo.green  = '{red_min: 0, green_min: 100, blue_min: 0,
                        red_max: '1, green_max: '1, blue_max: '1};
        demo.red    = '{red_min: 100, green_min: 0, blue_min: 0,
                        red_max: '1, green_max: '1, blue_max: '1};
        demo.white  = '{red_min: 500, green_min: 500, blue_min: 500,
                        red_max: '1, green_max: '1, blue_max: '1};
        demo.yellow = '{red_min: 300, green_min: 300, blue_min: 0,
                        red_max: '1, green_max: '1, blue_max: 299};
        demo.dark_cutoff = 200;
        load_settings(demo);
        send_levels(5, 10, 10);
        send_levels(11, 0, 0);
        send_levels(40, 40, 40);
        send_levels(60, 60, 60);
        send_levels(61, 30, 30);
        send_levels(50, 50, 500);
        send_levels(500, 0, 500);
        send_levels(50, 500, 50);
        send_levels(500, 50, 50);
        send_levels(600, 600, 600);
        send_reading('{red_lit: '1, red_unlit: '0, green_lit: '1, green_unlit: '0,
                       blue_lit: '1, blue_unlit: '0});
        send_levels(400, 400, 100);
        send_levels(200, 20, 20);
        send_levels(201, 20, 20);
        // Differences of exactly the margin and one above it.
        send_reading('{red_lit: 103, red_unlit: 100, green_lit: 504, green_unlit: 500,
                       blue_lit: 20, blue_unlit: 900});
        settle_results();

        // A blue window with its minimum above its maximum can never match.
        demo.blue = '{red_min: 0, green_min: 0, blue_min: 500,
                      red_max: '1, green_max: '1, blue_max: 100};
        demo.dark_cutoff = '1;
        load_settings(demo);
        send_levels(50, 50, 500);
        send_levels(50, 50, 300);
        settle_results();

        // Random settings; the first takes every window at full range.
        for (int unsigned set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
            demo = random_settings();
            if (set_idx == 0) begin
                demo.black = FULL_WINDOW;
                demo.blue = FULL_WINDOW;
                demo.green = FULL_WINDOW;
                demo.red = FULL_WINDOW;
                demo.white = FULL_WINDOW;
                demo.yellow = FULL_WINDOW;
                demo.dark_cutoff = '1;
            end
            no_idle = (set_idx == 2);
            load_settings(demo);
            for (int unsigned k = 0; k < WORDS_PER_SET; k++) begin
                send_random_reading();
            end
            settle_results();
        end
        no_idle = 1'b0;

        repeat (8) @(posedge aclk);
        $display("Sent %0d reading words under %0d register settings, checked %0d results.",
                 words_sent, settings_loaded + 1, sb.words_checked);
        $display("Classes seen: none %0d, black %0d, blue %0d, green %0d, %s %0d, %s %0d, %s %0d, %s %0d.",
                 sb.class_seen[CLS_NONE], sb.class_seen[CLS_BLACK], sb.class_seen[CLS_BLUE],
                 sb.class_seen[CLS_GREEN], "red", sb.class_seen[CLS_RED],
                 "white", sb.class_seen[CLS_WHITE], "yellow", sb.class_seen[CLS_YELLOW],
                 "unknown", sb.class_seen[CLS_UNKNOWN]);
        if (sb.mismatches == 0) begin
            $display("[rgb_reflectance_color_classifier_top] OK");
        end else begin
            $display("[rgb_reflectance_color_classifier_top] ERROR");
        end
        $finish;
    end

endmodule
